@@ hdl/wodo_pkg.sv @@
// ----------------------------------------------------------------------------
// wodo_pkg
// Shared types and constants for the wheel odometer integrator.
// ----------------------------------------------------------------------------
package wodo_pkg;

  localparam int SPEED_BITS = 16;
  localparam int NUM_W      = SPEED_BITS + 1;   // speed sum / speed delta
  localparam int DVD_W      = 33;               // serial divider dividend width
  localparam int ITER_W     = 6;                // divider step count width
  localparam int MS_PER_S   = 1000;

  // x / MS_PER_S == (x * RCP_MS) >> (32 + RCP_SHIFT) for any 32-bit x
  localparam logic [31:0] RCP_MS    = 32'h1062_4DD3;
  localparam int          RCP_SHIFT = 6;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [31:0]                  now_ms;
    logic signed [SPEED_BITS-1:0] speed_right;
    logic signed [SPEED_BITS-1:0] speed_left;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               measuring;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ hdl/wodo_div.sv @@
// ----------------------------------------------------------------------------
// wodo_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// left aligned; after iters steps the quotient sits in the low bits.
// ----------------------------------------------------------------------------
module wodo_div import wodo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quotient
);

  logic [31:0]       rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [32:0]       trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/wodo_mul.sv @@
// ----------------------------------------------------------------------------
// wodo_mul
// Shared 32x32 multiplier, full product registered; low and high words out.
// ----------------------------------------------------------------------------
module wodo_mul import wodo_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p,
  output logic [31:0] ph
);

  logic [63:0] full;
  logic [63:0] p_r, p_nxt;

  assign full  = 64'(a) * 64'(b);
  assign p_nxt = full;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p  = p_r[31:0];
  assign ph = p_r[63:32];

endmodule

@@ hdl/wheel_odometer_integrator_unit.sv @@
// ----------------------------------------------------------------------------
// Start, stop and idle words go from accept straight to the output state; an
// update while measuring runs the acceleration divide (skipped with no elapsed
// time), the multiplies, the reciprocal multiply and the sum. The serial divide
// makes one quotient bit per cycle, SPEED_BITS + 1 bits; divide by 1000 is a
// reciprocal multiply. One word at a time. Reset (synchronous, rst_n low):
// distance, stored speed and time cleared, measuring off, no result pending.
// ----------------------------------------------------------------------------
// wheel_odometer_integrator_unit
// Sequencer and state around a shared divider and multiplier.
// ----------------------------------------------------------------------------
module wheel_odometer_integrator_unit import wodo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ACC  = 4'd1;
  localparam logic [3:0] ST_DIVA = 4'd2;
  localparam logic [3:0] ST_M1   = 4'd3;
  localparam logic [3:0] ST_M2   = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_M4   = 4'd6;
  localparam logic [3:0] ST_RCP  = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam int ITERS_A = NUM_W;

  logic [3:0]                   state_r, state_nxt;
  logic                         active_r, active_nxt;
  logic [31:0]                  total_r, total_nxt;
  logic signed [SPEED_BITS-1:0] prev_speed_r, prev_speed_nxt;
  logic [31:0]                  prev_time_r, prev_time_nxt;
  logic [31:0]                  now_r, now_nxt;
  logic [31:0]                  t_r, t_nxt;
  logic signed [SPEED_BITS-1:0] v_r, v_nxt;
  logic [NUM_W-1:0]             mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic [31:0]                  acc_r, acc_nxt;
  logic [31:0]                  half_r, half_nxt;
  logic [31:0]                  cmag_r, cmag_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_word_t                    out_data_r, out_data_nxt;

  logic              accept;
  logic signed [NUM_W-1:0] sum, sum_adj, num;
  logic [31:0]       ps_ext, h, cur, cur_mag, q_lo, q_ms;
  logic              out_free;

  div_req_t          div_req;
  div_sts_t          div_sts;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [31:0]       div_dvs;
  logic [31:0]       mul_a, mul_b, mul_p, mul_ph;

  wodo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  wodo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p),
    .ph  (mul_ph)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // average speed, truncated toward zero
  assign sum     = NUM_W'(in_data.speed_right) + NUM_W'(in_data.speed_left);
  assign sum_adj = sum + NUM_W'(sum[NUM_W-1]);
  assign v_nxt   = sum_adj[NUM_W-1:1];
  assign num     = NUM_W'(v_nxt) - NUM_W'(prev_speed_r);

  assign ps_ext  = 32'(prev_speed_r);
  assign h       = mul_p + 32'(mul_p[31]);   // p2 / 2 toward zero
  assign cur     = mul_p + half_r;
  assign cur_mag = cur[31] ? 32'(-cur) : cur;
  assign q_lo    = div_quo[31:0];
  assign q_ms    = mul_ph >> RCP_SHIFT;      // |cur| / 1000

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_M1: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      ST_M2: begin
        mul_a = acc_r;
        mul_b = mul_p;
      end
      ST_M3: begin
        mul_a = ps_ext;
        mul_b = t_r;
      end
      ST_RCP: begin
        mul_a = cmag_r;
        mul_b = RCP_MS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    total_nxt      = total_r;
    prev_speed_nxt = prev_speed_r;
    prev_time_nxt  = prev_time_r;
    now_nxt        = now_r;
    t_nxt          = t_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    half_nxt       = half_r;
    cmag_nxt       = cmag_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    div_req.start  = 1'b0;
    div_req.iters  = ITER_W'(ITERS_A);
    div_dvd        = DVD_W'(mag_r) << (DVD_W - NUM_W);
    div_dvs        = t_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_OUT;
          if (in_data.opcode == OP_START) begin
            active_nxt = 1'b1;
            total_nxt  = '0;
          end else if (in_data.opcode == OP_STOP) begin
            active_nxt = 1'b0;
          end else if (in_data.opcode == OP_UPDATE && active_r) begin
            now_nxt   = in_data.now_ms;
            t_nxt     = in_data.now_ms - prev_time_r;
            mag_nxt   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            neg_nxt   = num[NUM_W-1];
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (t_r == '0) begin
          acc_nxt   = '0;
          state_nxt = ST_M1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (div_sts.done) begin
          acc_nxt   = neg_r ? 32'(-q_lo) : q_lo;
          state_nxt = ST_M1;
        end
      end
      ST_M1: state_nxt = ST_M2;
      ST_M2: state_nxt = ST_M3;
      ST_M3: begin
        half_nxt  = {h[31], h[31:1]};
        state_nxt = ST_M4;
      end
      ST_M4: begin
        cmag_nxt  = cur_mag;
        neg_nxt   = cur[31];
        state_nxt = ST_RCP;
      end
      ST_RCP: state_nxt = ST_SUM;
      ST_SUM: begin
        total_nxt      = total_r + (neg_r ? 32'(-q_ms) : q_ms);
        prev_speed_nxt = v_r;
        prev_time_nxt  = now_r;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.distance   = total_r;
          out_data_nxt.measuring  = active_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= 1'b0;
      total_r      <= '0;
      prev_speed_r <= '0;
      prev_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      total_r      <= total_nxt;
      prev_speed_r <= prev_speed_nxt;
      prev_time_r  <= prev_time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    t_r        <= t_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    half_r     <= half_nxt;
    cmag_r     <= cmag_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_sts.busy)
    else $error("divider busy while sequencer idle");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result word raised outside output state");

  a_out_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=>
      (out_data_r.distance == total_r && out_data_r.measuring == active_r))
    else $error("result word does not match distance state");
`endif

endmodule

@@ tb/wheel_odometer_integrator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// wheel_odometer_integrator_unit_tb
// Drives start/stop/update words through the odometer, predicts the distance
// and measuring flag of every word, and checks each result word in order.
// The run mixes random idle gaps and output stalls on both sides.
// ----------------------------------------------------------------------------
module wheel_odometer_integrator_unit_tb import wodo_pkg::*; ();

  localparam int CLK_HALF   = 6;
  localparam int MAX_CYCLES = 1_200_000;
  localparam int SETTLE     = 80;
  localparam int HOLD_LONG  = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  // odometer state as predicted
  logic signed [31:0]           odo_dist;
  logic signed [SPEED_BITS-1:0] odo_speed;
  logic [31:0]                  odo_time;
  logic                         odo_active;

  out_word_t   dist_q[$];
  out_word_t   want_word;
  int          err_cnt;
  int          n_sent;
  bit          idle_en;
  int          long_hold;
  int          stall_left;
  logic [31:0] clk_ms;

  wheel_odometer_integrator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic out_word_t predict_distance(in_word_t w);
    longint      v;
    longint      acc;
    longint      half;
    longint      inc;
    logic [31:0] t;
    logic [31:0] tt;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] cur;
    out_word_t   r;
    if (w.opcode == OP_START) begin
      odo_active = 1'b1;
      odo_dist   = '0;
    end else if (w.opcode == OP_STOP) begin
      odo_active = 1'b0;
    end else if (w.opcode == OP_UPDATE && odo_active) begin
      v   = (longint'(w.speed_right) + longint'(w.speed_left)) / 2;
      t   = w.now_ms - odo_time;
      acc = 0;
      if (t != 0)
        acc = (v - longint'(odo_speed)) / longint'({32'd0, t});
      tt   = t * t;
      p1   = 32'(longint'(odo_speed) * longint'(signed'(t)));
      p2   = 32'(acc * longint'(signed'(tt)));
      half = longint'(signed'(p2)) / 2;
      cur  = p1 + half[31:0];
      inc  = longint'(signed'(cur)) / MS_PER_S;
      odo_dist   = odo_dist + inc[31:0];
      odo_speed  = v[SPEED_BITS-1:0];
      odo_time   = w.now_ms;
    end
    r.distance  = odo_dist;
    r.measuring = odo_active;
    return r;
  endfunction

  function automatic in_word_t mk_word(logic [1:0] op, logic [31:0] now,
                                       logic [15:0] vr, logic [15:0] vl);
    in_word_t w;
    w.opcode      = op;
    w.now_ms      = now;
    w.speed_right = vr;
    w.speed_left  = vl;
    return w;
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2, 3:    return $urandom_range(1, 20);
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_cnt++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    dist_q.push_back(predict_distance(w));
    if (w.opcode != OP_UNUSED)
      n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
  endtask

  // receiver: a requested long hold-off takes priority, then random stall bursts
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (dist_q.size() == 0) begin
        report_mismatch("unexpected word", out_data.distance, 0);
      end else begin
        want_word = dist_q.pop_front();
        if (out_data.distance !== want_word.distance)
          report_mismatch("distance", out_data.distance, want_word.distance);
        if (out_data.measuring !== want_word.measuring)
          report_mismatch("measuring", out_data.measuring, want_word.measuring);
      end
    end
  end

  // updates, idle opcode and stop before anything was started
  task automatic test_idle_words();
    send_word(mk_word(OP_UPDATE, 32'd100, 16'h7fff, 16'h7fff));
    send_word(mk_word(OP_UNUSED, 32'd200, 16'h1234, 16'h8000));
    send_word(mk_word(OP_STOP, 32'd300, 16'h0000, 16'hffff));
  endtask

  task automatic test_start_update();
    send_word(mk_word(OP_START, 32'd0, 16'h0000, 16'h0000));
    // elapsed time zero, stored time is still zero
    send_word(mk_word(OP_UPDATE, 32'd0, 16'h0064, 16'h0064));
    send_word(mk_word(OP_UPDATE, 32'd1000, 16'h7fff, 16'h7fff));
    send_word(mk_word(OP_UPDATE, 32'd2000, 16'h8000, 16'h8000));
    // sum of -1 averages to zero (truncation)
    send_word(mk_word(OP_UPDATE, 32'd2500, 16'h7fff, 16'h8000));
    send_word(mk_word(OP_UPDATE, 32'd2501, 16'hffff, 16'h0000));
    send_word(mk_word(OP_UPDATE, 32'd2501, 16'h0064, 16'h0064));
  endtask

  task automatic test_time_extremes();
    send_word(mk_word(OP_UPDATE, 32'hffff_fff0, 16'h7fff, 16'h7fff));
    // time wraps past zero
    send_word(mk_word(OP_UPDATE, 32'h0000_0010, 16'h8000, 16'h7fff));
    // t*t beyond 2^31 reads negative
    send_word(mk_word(OP_UPDATE, 32'd50016, 16'hb1e0, 16'hb1e0));
    send_word(mk_word(OP_UPDATE, 32'hffff_ffff, 16'h0001, 16'hfffe));
    send_word(mk_word(OP_UNUSED, 32'h5555_aaaa, 16'h5555, 16'haaaa));
  endtask

  // start keeps stored speed and time; stopped updates are ignored
  task automatic test_stop_restart();
    send_word(mk_word(OP_STOP, 32'h0000_1000, 16'h0100, 16'h0100));
    send_word(mk_word(OP_UPDATE, 32'h0000_2000, 16'h7000, 16'h7000));
    send_word(mk_word(OP_START, 32'h0000_3000, 16'h0200, 16'h0200));
    send_word(mk_word(OP_UPDATE, 32'h0000_4000, 16'h3000, 16'h1000));
    send_word(mk_word(OP_UPDATE, 32'h0000_4400, 16'hc000, 16'hd000));
    send_word(mk_word(OP_STOP, 32'h0000_5000, 16'h0000, 16'h0000));
    clk_ms = 32'h0000_5000;
  endtask

  task automatic test_random(int n);
    int target;
    int k;
    target = n_sent + n;
    while (n_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        clk_ms += rand_step();
        send_word(mk_word(OP_START, clk_ms, rand_speed(), rand_speed()));
        k = $urandom_range(1, 30);
        repeat (k) begin
          clk_ms += rand_step();
          send_word(mk_word(OP_UPDATE, clk_ms, rand_speed(), rand_speed()));
        end
        if ($urandom_range(0, 2) == 0)
          send_word(mk_word(OP_STOP, clk_ms + rand_step(), rand_speed(), rand_speed()));
      end else begin
        send_word(mk_word(2'($urandom_range(0, 3)), $urandom, 16'($urandom),
                          16'($urandom)));
      end
    end
  endtask

  // output held off while the sender keeps offering words
  task automatic test_backpressure();
    @(posedge clk);
    long_hold = HOLD_LONG;
    idle_en   = 1'b0;
    clk_ms += 32'd10;
    send_word(mk_word(OP_START, clk_ms, 16'h0010, 16'h0010));
    repeat (12) begin
      clk_ms += rand_step();
      send_word(mk_word(OP_UPDATE, clk_ms, rand_speed(), rand_speed()));
    end
    wait_drained();
    idle_en = 1'b1;
  endtask

  // sender stops until every result is back, then carries on
  task automatic test_drain_pause();
    repeat (3) begin
      test_random(20);
      wait_drained();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    err_cnt   = 0;
    n_sent    = 0;
    idle_en   = 1'b0;
    long_hold = 0;
    clk_ms    = '0;
    odo_dist   = '0;
    odo_speed  = '0;
    odo_time   = '0;
    odo_active = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_words();
    test_start_update();
    test_time_extremes();
    test_stop_restart();
    idle_en = 1'b1;
    test_random(500);
    test_backpressure();
    test_drain_pause();
    test_random(400);
    idle_en = 1'b0;
    test_random(200);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * MAX_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
